// ===== rtl/ris_pkg.sv =====
// Package for the reprojection inlier scorer: widths, register indexes,
// shared structs and fixed constants. No dependencies.
package ris_pkg;

    localparam int MaxPoints = 4096;
    localparam int IdxW      = 12;
    localparam int CntW      = 13;
    localparam int SumW      = 48;
    localparam int AddrW     = 6;

    localparam logic [IdxW-1:0] IndexTop =
        (MaxPoints - 1 < 4095) ? IdxW'(MaxPoints - 1) : IdxW'(4095);
    localparam logic [CntW-1:0] InlierTop = {1'b0, IndexTop} + CntW'(1);
    localparam logic [SumW-1:0] SumTop = '1;

    typedef enum logic [2:0] {
        REG_R0C01 = 3'd0,
        REG_R0C2X = 3'd1,
        REG_R1C01 = 3'd2,
        REG_R1C2Y = 3'd3,
        REG_R2C01 = 3'd4,
        REG_R2C2Z = 3'd5,
        REG_THR   = 3'd6,
        REG_NONE  = 3'd7
    } t_reg_idx;

    // one accepted point, as it crosses from the front to the back
    typedef struct packed {
        logic signed [31:0] cam_u;
        logic signed [31:0] cam_v;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic               last;
    } t_point;

    // rotation r[row][col] and shift t[row], each a signed Q16.16 word
    typedef struct packed {
        logic [2:0][2:0][31:0] r;
        logic [2:0][31:0]      t;
        logic [31:0]           thr;
    } t_pose;

    // results leaving the back part
    typedef struct packed {
        logic [IdxW-1:0] point_index;
        logic            is_inlier;
        logic [31:0]     squared_error;
        logic [CntW-1:0] inlier_count;
        logic [SumW-1:0] error_sum;
        logic            zero_depth;
        logic            set_done;
    } t_result;

endpackage

// ===== rtl/ris_front.sv =====
// Front part: configuration registers and point intake into a two-entry queue.
// Depends on ris_pkg.
module ris_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ris_pkg::AddrW-1:0] paddr,
    input  logic [63:0]             pwdata,
    output logic [63:0]             prdata,
    input  logic                    i_pt_valid,
    output logic                    o_pt_ready,
    input  ris_pkg::t_point         i_pt,
    output logic                    o_q_valid,
    input  logic                    i_q_take,
    output ris_pkg::t_point         o_q_pt,
    output ris_pkg::t_pose          o_pose
);
    localparam int AddrW_L = ris_pkg::AddrW - 1;

    logic [63:0] r_reg [0:6];
    ris_pkg::t_point r_q [0:1];
    logic [1:0] r_cnt;
    logic w_rd;
    logic w_acc;
    logic w_to_head;
    ris_pkg::t_reg_idx w_idx;

    assign w_idx = (paddr[AddrW_L:3] > 3'd6) ? ris_pkg::REG_NONE
                 : ris_pkg::t_reg_idx'(paddr[AddrW_L:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg[0] <= 64'd65536;
            r_reg[1] <= '0;
            r_reg[2] <= 64'd281474976710656;
            r_reg[3] <= '0;
            r_reg[4] <= '0;
            r_reg[5] <= 64'd65536;
            r_reg[6] <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                ris_pkg::REG_NONE: ;
                ris_pkg::REG_THR:  r_reg[6] <= {32'd0, pwdata[31:0]};
                default:           r_reg[w_idx] <= pwdata;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ris_pkg::REG_NONE: prdata = '0;
            default:           prdata = r_reg[w_idx];
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_pose.r[i][0] = r_reg[2*i][31:0];
            o_pose.r[i][1] = r_reg[2*i][63:32];
            o_pose.r[i][2] = r_reg[2*i+1][31:0];
            o_pose.t[i]    = r_reg[2*i+1][63:32];
        end
        o_pose.thr = r_reg[6][31:0];
    end

    // two-entry queue; the front part may accept while the back part stalls
    assign o_pt_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_pt     = r_q[0];
    assign w_rd       = o_q_valid && i_q_take;
    assign w_acc      = i_pt_valid && o_pt_ready;
    assign w_to_head  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && w_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_acc} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_to_head) r_q[0] <= i_pt;
        else if (w_rd) r_q[0] <= r_q[1];
        if (w_acc && !w_to_head) r_q[1] <= i_pt;
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue over");
    a_no_full_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_pt_ready) else $error("accept when full");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 && !i_pt_valid |=> r_cnt == 2'd0) else $error("spurious entry");
`endif
endmodule

// ===== rtl/ris_back.sv =====
// Back part: transform, iterative projection divide, error and set totals.
// Depends on ris_pkg.
module ris_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_take,
    input  ris_pkg::t_point   i_q_pt,
    input  ris_pkg::t_pose    i_pose,
    output logic              o_valid,
    input  logic              i_ready,
    output ris_pkg::t_result  o_res
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_SUM  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_ERR  = 7'b0010000,
        S_ACC  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_st;
    ris_pkg::t_point r_pt;
    logic [1:0]  r_row;
    logic signed [63:0] r_p [0:2];
    logic signed [48:0] r_xyz [0:2];
    logic [6:0]  r_cnt;
    logic [1:0]  r_dsel;
    logic [47:0] r_b;
    logic [63:0] r_dvd;
    logic [47:0] r_rem;
    logic [40:0] r_qo;
    logic        r_big;
    logic signed [41:0] r_proj [0:1];
    logic [31:0] r_sq;
    logic        r_inl;
    logic        r_zero;
    logic [ris_pkg::IdxW-1:0] r_idx;
    logic [ris_pkg::CntW-1:0] r_icnt;
    logic [ris_pkg::SumW-1:0] r_sum;
    logic        r_sq_phase;
    logic [47:0] r_du2;

    logic signed [63:0] w_prod;
    logic signed [31:0] w_coef, w_coord;
    logic [48:0] w_a;
    logic [48:0] w_b;
    logic [48:0] w_sh;
    logic [48:0] w_dif;
    logic signed [41:0] w_mag;
    logic signed [43:0] w_d;
    logic [43:0] w_ad;
    logic [47:0] w_m;
    logic [48:0] w_nsum;
    logic [48:0] w_tot;

    function automatic logic signed [48:0] fl16(input logic signed [63:0] v);
        fl16 = 49'(v >>> 16);
    endfunction

    assign o_q_take = (r_st == S_IDLE) && i_q_valid;

    // one multiplier shared over the three coefficients of a row
    always_comb begin
        w_coef = i_pose.r[r_row][r_cnt[1:0]];
        case (r_cnt[1:0])
            2'd0:    w_coord = r_pt.wx;
            2'd1:    w_coord = r_pt.wy;
            default: w_coord = r_pt.wz;
        endcase
        w_prod = 64'(w_coef) * 64'(w_coord);
    end

    always_comb begin
        w_a   = r_xyz[r_dsel][48] ? 49'(-r_xyz[r_dsel]) : 49'(r_xyz[r_dsel]);
        w_b   = r_xyz[2][48] ? 49'(-r_xyz[2]) : 49'(r_xyz[2]);
        w_sh  = {r_rem, r_dvd[63]};
        w_dif = w_sh - {1'b0, r_b};
        // quotients past 2^40 clamp there; they saturate the error anyway
        w_mag = (r_big || r_qo[40]) ? {2'b01, 40'd0} : {2'b00, r_qo[39:0]};
        w_d  = 44'(r_pt.cam_u) - 44'(r_proj[0]);
        if (r_sq_phase) w_d = 44'(r_pt.cam_v) - 44'(r_proj[1]);
        w_ad = w_d[43] ? -w_d : w_d;
        w_m  = {24'd0, w_ad[23:0]} * {24'd0, w_ad[23:0]};
        w_tot = {1'b0, r_du2} + {1'b0, w_m};
        w_nsum = 49'(r_sum) + 49'(r_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_idx  <= '0;
            r_icnt <= '0;
            r_sum  <= '0;
        end else begin
            case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_pt  <= i_q_pt;
                    r_row <= '0;
                    r_cnt <= '0;
                    r_st  <= S_MUL;
                end
                S_MUL: begin
                    r_p[r_cnt[1:0]] <= w_prod;
                    if (r_cnt[1:0] == 2'd2) begin
                        r_st <= S_SUM;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_SUM: begin
                    r_xyz[r_row] <= fl16(r_p[0]) + fl16(r_p[1]) + fl16(r_p[2])
                                  + 49'(signed'(i_pose.t[r_row]));
                    r_cnt <= '0;
                    if (r_row == 2'd2) begin
                        r_dsel <= '0;
                        r_st   <= S_DIV;
                    end else begin
                        r_row <= r_row + 2'd1;
                        r_st  <= S_MUL;
                    end
                end
                S_DIV: begin
                    // restoring divide of |n|<<16 by |Z|, one bit a cycle
                    if (r_xyz[2] == '0) begin
                        r_zero <= 1'b1;
                        r_st   <= S_ACC;
                        r_sq   <= '1;
                        r_inl  <= 1'b0;
                    end else if (r_cnt == 7'd0) begin
                        r_zero <= 1'b0;
                        r_b    <= w_b[47:0];
                        r_dvd  <= {w_a[47:0], 16'd0};
                        r_rem  <= '0;
                        r_qo   <= '0;
                        r_big  <= 1'b0;
                        r_cnt  <= 7'd1;
                    end else if (r_cnt <= 7'd64) begin
                        r_dvd <= {r_dvd[62:0], 1'b0};
                        r_big <= r_big | r_qo[40];
                        if (w_sh >= {1'b0, r_b}) begin
                            r_rem <= w_dif[47:0];
                            r_qo  <= {r_qo[39:0], 1'b1};
                        end else begin
                            r_rem <= w_sh[47:0];
                            r_qo  <= {r_qo[39:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 7'd1;
                    end else begin
                        r_proj[r_dsel[0]] <=
                            (r_xyz[r_dsel][48] != r_xyz[2][48]) ? -w_mag : w_mag;
                        r_cnt <= '0;
                        if (r_dsel == 2'd1) begin
                            r_sq_phase <= 1'b0;
                            r_st <= S_ERR;
                        end else begin
                            r_dsel <= 2'd1;
                        end
                    end
                end
                S_ERR: begin
                    if (w_ad >= 44'd16777216) begin
                        r_sq  <= '1;
                        r_inl <= 1'b0;
                        r_st  <= S_ACC;
                    end else if (!r_sq_phase) begin
                        r_du2 <= w_m;
                        r_sq_phase <= 1'b1;
                    end else begin
                        r_sq  <= w_tot[48] ? '1 : w_tot[47:16];
                        r_inl <= (w_tot[48] ? 32'hFFFFFFFF : w_tot[47:16]) < i_pose.thr;
                        r_st  <= S_ACC;
                    end
                end
                S_ACC: begin
                    o_res.point_index   <= r_idx;
                    o_res.is_inlier     <= r_inl;
                    o_res.squared_error <= r_sq;
                    o_res.inlier_count  <= (r_inl && r_icnt < ris_pkg::InlierTop)
                                         ? r_icnt + 1'b1 : r_icnt;
                    o_res.error_sum     <= w_nsum[48] ? ris_pkg::SumTop : w_nsum[47:0];
                    o_res.zero_depth    <= r_zero;
                    o_res.set_done      <= r_pt.last;
                    if (r_pt.last) begin
                        r_idx <= '0; r_icnt <= '0; r_sum <= '0;
                    end else begin
                        if (r_idx < ris_pkg::IndexTop) r_idx <= r_idx + 1'b1;
                        if (r_inl && r_icnt < ris_pkg::InlierTop) r_icnt <= r_icnt + 1'b1;
                        r_sum <= w_nsum[48] ? ris_pkg::SumTop : w_nsum[47:0];
                    end
                    r_st <= S_OUT;
                end
                S_OUT: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid = (r_st == S_OUT);

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res)) else $error("result dropped");
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.zero_depth |-> !o_res.is_inlier) else $error("zero depth inlier");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_take |=> r_st == S_MUL) else $error("take without start");
`endif
endmodule

// ===== rtl/reprojection_inlier_scorer.sv =====
// Top level of the reprojection inlier scorer: front intake, back scoring.
// Depends on ris_pkg, ris_front, ris_back.
//
//  channel  dir  handshake               contents
//  s_axis   in   s_axis_tvalid/tready    cam_u,cam_v,world_x,y,z ; tlast last_point
//  m_axis   out  m_axis_tvalid/tready    result fields ; tlast set_done
//  apb      in   psel/penable/pready     pose and threshold registers
//
// Each point runs nine multiplies on one shared multiplier and two 64-step
// bit-serial divides; a zero depth skips the divides. A new point is taken
// only when the back part is idle again. Reset is synchronous, active low,
// and clears counters and the pose to identity. A two-entry queue lets
// intake continue while a result waits on m_axis_tready.
module reprojection_inlier_scorer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ris_pkg::AddrW-1:0] paddr,
    input  logic [63:0]               pwdata,
    output logic [63:0]               prdata,
    output logic                      pready,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // cam_u, cam_v, world_x, world_y, world_z
    input  logic [159:0]              s_axis_tdata,
    // last_point
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // point_index, is_inlier, squared_error, inlier_count, error_sum, zero_depth, pad
    output logic [111:0]              m_axis_tdata,
    output logic                      m_axis_tlast
);
    ris_pkg::t_point  w_pt, w_qpt;
    ris_pkg::t_pose   w_pose;
    ris_pkg::t_result w_res;
    logic w_qv, w_take;

    assign pready = 1'b1;
    assign w_pt.cam_u = s_axis_tdata[31:0];
    assign w_pt.cam_v = s_axis_tdata[63:32];
    assign w_pt.wx    = s_axis_tdata[95:64];
    assign w_pt.wy    = s_axis_tdata[127:96];
    assign w_pt.wz    = s_axis_tdata[159:128];
    assign w_pt.last  = s_axis_tlast;

    ris_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata),
        .i_pt_valid(s_axis_tvalid), .o_pt_ready(s_axis_tready), .i_pt(w_pt),
        .o_q_valid(w_qv), .i_q_take(w_take), .o_q_pt(w_qpt), .o_pose(w_pose)
    );

    ris_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_qv), .o_q_take(w_take), .i_q_pt(w_qpt), .i_pose(w_pose),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {5'd0, w_res.zero_depth, w_res.error_sum, w_res.inlier_count,
                           w_res.squared_error, w_res.is_inlier, w_res.point_index};
    assign m_axis_tlast = w_res.set_done;
endmodule

// ===== bench/ris_checker.sv =====
`timescale 1ns / 1ps
// Checker for the reprojection inlier scorer: watches the point and result
// streams and the register port, scores each point and compares. Uses ris_pkg.
module ris_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ris_pkg::AddrW-1:0] paddr,
    input  logic [63:0]               pwdata,
    input  logic                      pready,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [159:0]              s_axis_tdata,
    input  logic                      s_axis_tlast,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [111:0]              m_axis_tdata,
    input  logic                      m_axis_tlast,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_scored
);
    logic [63:0] pose_reg [0:5];
    logic [31:0] thr_reg;
    logic [11:0] idx_cnt;
    logic [12:0] inl_cnt;
    logic [47:0] err_acc;
    ris_pkg::t_result score_q[$];

    function automatic longint mul_floor(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic longint s32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint pose_row(int r, longint x, longint y, longint z);
        return mul_floor(s32(pose_reg[2*r][31:0]), x) + mul_floor(s32(pose_reg[2*r][63:32]), y)
             + mul_floor(s32(pose_reg[2*r+1][31:0]), z) + s32(pose_reg[2*r+1][63:32]);
    endfunction

    function automatic longint proj_div(longint n, longint d);
        logic [63:0] a, b, ip, rem, q;
        a = n < 0 ? -n : n;
        b = d < 0 ? -d : d;
        ip = a / b;
        rem = a % b;
        if (ip >= 64'd1 << 24) begin
            q = 64'd1 << 40;
        end else begin
            q = ip;
            for (int i = 0; i < 16; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= b) begin
                    rem = rem - b;
                    q[0] = 1'b1;
                end
            end
            if (q > 64'd1 << 40) q = 64'd1 << 40;
        end
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic ris_pkg::t_result score_point(logic [159:0] pt, logic last);
        ris_pkg::t_result res;
        longint u, v, wx, wy, wz, px, py, pz, du, dv;
        logic [63:0] s, sq;
        logic inl;
        u = s32(pt[31:0]);
        v = s32(pt[63:32]);
        wx = s32(pt[95:64]);
        wy = s32(pt[127:96]);
        wz = s32(pt[159:128]);
        px = pose_row(0, wx, wy, wz);
        py = pose_row(1, wx, wy, wz);
        pz = pose_row(2, wx, wy, wz);
        inl = 1'b0;
        if (pz == 0) begin
            sq = 64'hFFFF_FFFF;
        end else begin
            du = u - proj_div(px, pz);
            dv = v - proj_div(py, pz);
            if (du >= (64'sd1 <<< 24) || du <= -(64'sd1 <<< 24) ||
                dv >= (64'sd1 <<< 24) || dv <= -(64'sd1 <<< 24)) begin
                sq = 64'hFFFF_FFFF;
            end else begin
                s = (64'(du * du) + 64'(dv * dv)) >> 16;
                sq = s > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : s;
            end
            inl = sq[31:0] < thr_reg;
        end
        if (inl && inl_cnt < ris_pkg::InlierTop) inl_cnt = inl_cnt + 1'b1;
        s = {16'd0, err_acc} + sq;
        err_acc = s > 64'(ris_pkg::SumTop) ? ris_pkg::SumTop : s[47:0];
        res.point_index = idx_cnt;
        res.is_inlier = inl;
        res.squared_error = sq[31:0];
        res.inlier_count = inl_cnt;
        res.error_sum = err_acc;
        res.zero_depth = pz == 0;
        res.set_done = last;
        if (last) begin
            idx_cnt = '0;
            inl_cnt = '0;
            err_acc = '0;
        end else if (idx_cnt < ris_pkg::IndexTop) begin
            idx_cnt = idx_cnt + 1'b1;
        end
        return res;
    endfunction

    task automatic cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    assign o_pending = score_q.size();

    always @(posedge i_clk) begin
        ris_pkg::t_result exp_r;
        logic [2:0] reg_sel;
        if (!i_rst_n) begin
            pose_reg[0] <= 64'd65536;
            pose_reg[1] <= 64'd0;
            pose_reg[2] <= 64'd1 << 48;
            pose_reg[3] <= 64'd0;
            pose_reg[4] <= 64'd0;
            pose_reg[5] <= 64'd65536;
            thr_reg <= '0;
            idx_cnt = '0;
            inl_cnt = '0;
            err_acc = '0;
            o_fail_count <= 0;
            o_scored <= 0;
            score_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                reg_sel = paddr[ris_pkg::AddrW-1:3];
                if (reg_sel == ris_pkg::REG_THR) thr_reg <= pwdata[31:0];
                else if (reg_sel < ris_pkg::REG_THR) pose_reg[reg_sel] <= pwdata;
            end
            if (s_axis_tvalid && s_axis_tready)
                score_q = {score_q, score_point(s_axis_tdata, s_axis_tlast)};
            if (m_axis_tvalid && m_axis_tready) begin
                o_scored <= o_scored + 1;
                if (score_q.size() == 0) begin
                    $error("result with no point outstanding");
                    o_fail_count++;
                end else begin
                    exp_r = score_q.pop_front();
                    // tdata from bit 0: point_index, is_inlier, squared_error,
                    // inlier_count, error_sum, zero_depth
                    cmp("point_index", exp_r.point_index, m_axis_tdata[11:0]);
                    cmp("is_inlier", exp_r.is_inlier, m_axis_tdata[12]);
                    cmp("squared_error", exp_r.squared_error, m_axis_tdata[44:13]);
                    cmp("inlier_count", exp_r.inlier_count, m_axis_tdata[57:45]);
                    cmp("error_sum", exp_r.error_sum, m_axis_tdata[105:58]);
                    cmp("zero_depth", exp_r.zero_depth, m_axis_tdata[106]);
                    cmp("set_done", exp_r.set_done, m_axis_tlast);
                end
            end
        end
    end
endmodule

// ===== bench/tb_reprojection_inlier_scorer.sv =====
`timescale 1ns / 1ps
// Testbench top for the reprojection inlier scorer: clock, reset, register
// writes, point stream and verdict. Depends on ris_pkg, reprojection_inlier_scorer and ris_checker.
module tb_reprojection_inlier_scorer;

    localparam int StallLimit = 20000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      psel, penable, pwrite;
    logic [ris_pkg::AddrW-1:0] paddr;
    logic [63:0]               pwdata, prdata;
    logic                      pready;
    logic                      s_axis_tvalid, s_axis_tready, s_axis_tlast;
    logic [159:0]              s_axis_tdata;
    logic                      m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [111:0]              m_axis_tdata;
    int                        fail_count, pending, scored;
    int                        idle_cycles;
    bit                        hold_off, timed_out;
    int                        sent, sets_done;

    reprojection_inlier_scorer u_top (.*);

    ris_checker u_chk (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .o_fail_count(fail_count), .o_pending(pending), .o_scored(scored)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stalls, stretches of none, one long hold-off on request
    initial begin
        int mode;
        int hold_n;
        m_axis_tready = 1'b0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                hold_n = 3000;
                m_axis_tready <= 1'b0;
                repeat (hold_n) @(posedge i_clk);
                hold_off = 1'b0;
            end
            if ($urandom_range(0, 99) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 3) != 0;
                default: m_axis_tready <= $urandom_range(0, 3) == 0;
            endcase
        end
    end

    // watchdog on accepted transactions of any kind
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || psel || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("tb_reprojection_inlier_scorer: FAIL");
            $finish;
        end
    end

    task automatic write_reg(ris_pkg::t_reg_idx idx, logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_point(logic [31:0] u, logic [31:0] v, logic [31:0] x,
                              logic [31:0] y, logic [31:0] z, logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x, v, u};
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
        if (last) sets_done++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] rnd_rot();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h0001_0000;
            2: return 32'hFFFF_0000;
            3: return $urandom();
            default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    // random points in sets of random length under the current pose
    task automatic run_sets(int n_items, int set_max, int kind_max);
        int left;
        int gap;
        left = 0;
        for (int i = 0; i < n_items; i++) begin
            if (left == 0) left = $urandom_range(1, set_max);
            if ($urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            left--;
            send_point(rnd_coord($urandom_range(0, kind_max)), rnd_coord($urandom_range(0, kind_max)),
                       rnd_coord($urandom_range(0, kind_max)), rnd_coord($urandom_range(0, kind_max)),
                       $urandom_range(0, 9) == 0 ? 32'd0 : rnd_coord($urandom_range(0, kind_max)),
                       left == 0 || i == n_items - 1);
        end
    endtask

    initial begin
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        hold_off = 1'b0;
        timed_out = 1'b0;
        sent = 0;
        sets_done = 0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity pose, zero threshold, then a generous one
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 0);
        send_point(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1);
        drain();
        write_reg(ris_pkg::REG_THR, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(ris_pkg::REG_NONE, 64'hDEAD_BEEF_0000_0000);
        send_point(32'h0000_8000, 32'h0, 32'h0000_8000, 32'h0, 32'h0001_0000, 0);
        send_point(32'h0, 32'h0, 32'h0003_0000, 32'hFFFE_0000, 32'hFFFF_0000, 0);
        send_point(32'h00FF_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 0);
        send_point(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1);
        drain();
        // all-ones and full-scale negative pose, with the shift landing depth on zero
        write_reg(ris_pkg::REG_R0C01, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(ris_pkg::REG_R0C2X, 64'h8000_0000_8000_0000);
        write_reg(ris_pkg::REG_R1C01, 64'h7FFF_FFFF_7FFF_FFFF);
        write_reg(ris_pkg::REG_R1C2Y, 64'h7FFF_FFFF_8000_0000);
        write_reg(ris_pkg::REG_R2C01, 64'h0);
        write_reg(ris_pkg::REG_R2C2Z, 64'hFFFF_0000_0001_0000);
        send_point(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0);
        send_point(32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0000, 0);
        send_point(32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 1);
        drain();

        // points under a long output hold-off, loose threshold, identity-like pose
        write_reg(ris_pkg::REG_R0C01, 64'h0000_0000_0001_0000);
        write_reg(ris_pkg::REG_R0C2X, 64'h0);
        write_reg(ris_pkg::REG_R1C01, 64'h0001_0000_0000_0000);
        write_reg(ris_pkg::REG_R1C2Y, 64'h0);
        write_reg(ris_pkg::REG_R2C01, 64'h0);
        write_reg(ris_pkg::REG_R2C2Z, 64'h0001_0000_0001_0000);
        write_reg(ris_pkg::REG_THR, 64'h0100_0000);
        hold_off = 1'b1;
        run_sets(40, 40, 2);
        drain();

        // random phases with fresh poses
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(ris_pkg::REG_R0C01, {rnd_rot(), rnd_rot()});
            write_reg(ris_pkg::REG_R0C2X, {rnd_coord(2), rnd_rot()});
            write_reg(ris_pkg::REG_R1C01, {rnd_rot(), rnd_rot()});
            write_reg(ris_pkg::REG_R1C2Y, {rnd_coord(2), rnd_rot()});
            write_reg(ris_pkg::REG_R2C01, {rnd_rot(), rnd_rot()});
            write_reg(ris_pkg::REG_R2C2Z, {rnd_coord(1), rnd_rot()});
            write_reg(ris_pkg::REG_THR,
                      ph == 5 ? 64'hFFFF_FFFF : {32'd0, $urandom()} >> $urandom_range(0, 31));
            run_sets(250, ph == 5 ? 5000 : 30, ph < 2 ? 3 : 2);
            drain();
        end

        $display("Scored %0d points over %0d sets, %0d results checked.", sent, sets_done, scored);
        $display("Covered extremes, zero depth, saturation and a long output hold-off.");
        if (fail_count == 0)
            $display("tb_reprojection_inlier_scorer: PASS");
        else
            $display("tb_reprojection_inlier_scorer: FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/ris_pkg.sv
rtl/ris_front.sv
rtl/ris_back.sv
rtl/reprojection_inlier_scorer.sv
bench/ris_checker.sv
bench/tb_reprojection_inlier_scorer.sv
